[rtl/bmo_pkg.sv]
// Package for the bilinear mesh offset block: field widths, command and
// register codes, and the stage-enable struct shared by the top level and the axis unit.
// No dependencies.
package bmo_pkg;

    localparam int POS_W      = 32;   // Q16.16 positions and grid origins
    localparam int POS_FRAC   = 16;
    localparam int FACTOR_W   = 24;   // Q0.24 reciprocal spacing
    localparam int FRAC_W     = 24;   // Q.24 blend ratio
    localparam int RATIO_W    = 32;   // ratio after saturation
    localparam int POINTS_W   = 5;
    localparam int CELL_W     = 4;
    localparam int HEIGHT_W   = 20;   // Q4.16 heights
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam int MAX_POINTS_X_DEF = 16;
    localparam int MAX_POINTS_Y_DEF = 16;
    localparam int POINTS_RESET     = 16;
    localparam int MIN_POINTS       = 2;

    typedef enum logic
    {
        CMD_WRITE = 1'b0,
        CMD_QUERY = 1'b1
    } cmd_t;

    typedef enum logic [CFG_IDX_W-1:0]
    {
        REG_START_X     = 3'd0,
        REG_START_Y     = 3'd1,
        REG_FACTOR_X    = 3'd2,
        REG_FACTOR_Y    = 3'd3,
        REG_POINTS_X    = 3'd4,
        REG_POINTS_Y    = 3'd5,
        REG_EXTRAPOLATE = 3'd6
    } cfg_reg_t;

    // Load enables of the three axis pipeline stages.
    typedef struct packed
    {
        logic s1;
        logic s2;
        logic s3;
    } axis_en_t;

endpackage

[rtl/bmo_if.sv]
// Channel interfaces of the bilinear mesh offset block: request, result and
// configuration write, each with valid/ready handshake. Depends on bmo_pkg.
interface bmo_req_if import bmo_pkg::*; ();
    logic                       valid;
    logic                       ready;
    cmd_t                       command;
    logic [CELL_W-1:0]          cell_x;
    logic [CELL_W-1:0]          cell_y;
    logic signed [HEIGHT_W-1:0] height_in;
    logic signed [POS_W-1:0]    pos_x;
    logic signed [POS_W-1:0]    pos_y;

    modport source (output valid, command, cell_x, cell_y, height_in, pos_x, pos_y,
                    input ready);
    modport sink   (input valid, command, cell_x, cell_y, height_in, pos_x, pos_y,
                    output ready);
endinterface

interface bmo_rsp_if import bmo_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [HEIGHT_W-1:0] z_offset;

    modport source (output valid, z_offset, input ready);
    modport sink   (input valid, z_offset, output ready);
endinterface

interface bmo_cfg_if import bmo_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[rtl/bmo_ram.sv]
// Generic single-write, single-read RAM with a registered, enabled read port.
// No dependencies.
module bmo_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/bmo_axis.sv]
// One axis of the mesh lookup: offset from the origin, scale by the reciprocal
// spacing, clamp to a cell index and take the blend ratio. Depends on bmo_pkg.
module bmo_axis import bmo_pkg::*; #(
    parameter int MAX_POINTS = MAX_POINTS_X_DEF,
    localparam int IW = $clog2(MAX_POINTS),
    localparam int PW = $clog2(MAX_POINTS + 1)
) (
    input  logic                      clk,
    input  axis_en_t                  en,
    input  logic signed [POS_W-1:0]   pos,
    input  logic signed [POS_W-1:0]   start,
    input  logic [FACTOR_W-1:0]       factor,
    input  logic [POINTS_W-1:0]       points,
    input  logic                      extrap,
    output logic [IW-1:0]             g,
    output logic [IW-1:0]             n,
    output logic signed [RATIO_W-1:0] f
);

    localparam int REL_W      = POS_W + 1;
    localparam int PROD_W     = REL_W + FACTOR_W + 1;
    localparam int CELL_SHIFT = POS_FRAC + FRAC_W;
    localparam int INT_W      = PROD_W - CELL_SHIFT;
    localparam int SHIFTED_W  = PROD_W - POS_FRAC;

    logic signed [REL_W-1:0]   rel_reg;
    logic signed [PROD_W-1:0]  r_reg;
    logic [IW-1:0]             g_reg;
    logic [IW-1:0]             n_reg;
    logic signed [RATIO_W-1:0] f_reg;

    logic [PW-1:0]                p_c;
    logic [PW-1:0]                last_c;
    logic [PW-1:0]                gp1_c;
    logic signed [INT_W-1:0]      rg_c;
    logic [IW-1:0]                g_next;
    logic [IW-1:0]                n_next;
    logic signed [SHIFTED_W-1:0]  fs_c;
    logic signed [SHIFTED_W-1:0]  gs_c;
    logic signed [SHIFTED_W-1:0]  f_full_c;
    logic signed [RATIO_W-1:0]    f_sat_c;
    logic signed [RATIO_W-1:0]    f_next;

    // Point count in use, held to the supported range.
    always_comb
    begin
        if (32'(points) < MIN_POINTS)
        begin
            p_c = PW'(MIN_POINTS);
        end
        else if (32'(points) > MAX_POINTS)
        begin
            p_c = PW'(MAX_POINTS);
        end
        else
        begin
            p_c = PW'(points);
        end
        last_c = extrap ? (p_c - PW'(2)) : (p_c - PW'(1));
    end

    // Cell index, neighbor index and ratio from the scaled position.
    always_comb
    begin
        rg_c = r_reg[PROD_W-1:CELL_SHIFT];
        if (rg_c[INT_W-1])
        begin
            g_next = '0;
        end
        else if (rg_c[INT_W-2:0] > (INT_W-1)'(last_c))
        begin
            g_next = last_c[IW-1:0];
        end
        else
        begin
            g_next = rg_c[IW-1:0];
        end

        gp1_c = PW'(g_next) + PW'(1);
        n_next = (gp1_c < p_c) ? gp1_c[IW-1:0] : IW'(p_c - PW'(1));

        // Remainder after removing whole cells, in Q.24.
        fs_c = r_reg[PROD_W-1:POS_FRAC];
        gs_c = SHIFTED_W'(g_next) << FRAC_W;
        f_full_c = fs_c - gs_c;
        if ((&f_full_c[SHIFTED_W-1:RATIO_W-1]) || !(|f_full_c[SHIFTED_W-1:RATIO_W-1]))
        begin
            f_sat_c = f_full_c[RATIO_W-1:0];
        end
        else if (f_full_c[SHIFTED_W-1])
        begin
            f_sat_c = {1'b1, {(RATIO_W-1){1'b0}}};
        end
        else
        begin
            f_sat_c = {1'b0, {(RATIO_W-1){1'b1}}};
        end
        f_next = (!extrap && f_sat_c[RATIO_W-1]) ? '0 : f_sat_c;
    end

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            rel_reg <= {pos[POS_W-1], pos} - {start[POS_W-1], start};
        end
        if (en.s2)
        begin
            r_reg <= rel_reg * $signed({1'b0, factor});
        end
        if (en.s3)
        begin
            g_reg <= g_next;
            n_reg <= n_next;
            f_reg <= f_next;
        end
    end

    assign g = g_reg;
    assign n = n_reg;
    assign f = f_reg;

endmodule

[rtl/bilinear_mesh_offset.sv]
// Top level of the bilinear mesh offset block: configuration registers, the
// banked height grid and the interpolation pipeline.
// Depends on bmo_pkg, bmo_if, bmo_axis and bmo_ram.
//
// Usage: req carries one transaction per item. A write (command CMD_WRITE)
// stores height_in at (cell_x, cell_y) and gives no result; cells beyond the
// grid are dropped. A query (command CMD_QUERY) gives one z_offset on rsp,
// the height at (pos_x, pos_y) blended from the four corners of its cell.
// cfg writes one register per transaction; it is always ready and must only
// be used while no query is in flight.
// Throughput is one item per cycle while rsp is not stalled. A query result
// reaches rsp through nine register stages:
// origin subtract, scale multiply, cell clamp, grid read, two ratio
// multiplies with their adds, and the final saturation.
// The grid sits in four RAM banks split by row and column parity, so the
// four corners of a cell are read together in the same cycle.
// When rsp is stalled, each stage holds only while the one after it is full,
// so req keeps accepting until the pipeline has no empty stage left.
// Reset empties the pipeline and loads the register defaults; grid contents
// are undefined until written and there is no clearing pass.
module bilinear_mesh_offset import bmo_pkg::*; #(
    parameter int MAX_POINTS_X = MAX_POINTS_X_DEF,
    parameter int MAX_POINTS_Y = MAX_POINTS_Y_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    bmo_req_if.sink   req,
    bmo_rsp_if.source rsp,
    bmo_cfg_if.sink   cfg
);

    localparam int IWX        = $clog2(MAX_POINTS_X);
    localparam int IWY        = $clog2(MAX_POINTS_Y);
    localparam int BX         = (MAX_POINTS_X + 1) / 2;
    localparam int BY         = (MAX_POINTS_Y + 1) / 2;
    localparam int BANK_DEPTH = BX * BY;
    localparam int BAW        = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
    localparam int NSTAGE     = 9;
    localparam int DIFF_W     = HEIGHT_W + 1;
    localparam int PY_W       = DIFF_W + RATIO_W;
    localparam int LR_W       = PY_W - FRAC_W + 1;
    localparam int D2_W       = LR_W + 1;
    localparam int PX_W       = D2_W + RATIO_W;
    localparam int Z_W        = PX_W - FRAC_W + 1;

    // Configuration registers.
    logic signed [POS_W-1:0] start_x_reg;
    logic signed [POS_W-1:0] start_y_reg;
    logic [FACTOR_W-1:0]     factor_x_reg;
    logic [FACTOR_W-1:0]     factor_y_reg;
    logic [POINTS_W-1:0]     points_x_reg;
    logic [POINTS_W-1:0]     points_y_reg;
    logic                    extrap_reg;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_x_reg  <= '0;
            start_y_reg  <= '0;
            factor_x_reg <= '0;
            factor_y_reg <= '0;
            points_x_reg <= POINTS_W'(POINTS_RESET);
            points_y_reg <= POINTS_W'(POINTS_RESET);
            extrap_reg   <= 1'b0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg_reg_t'(cfg.index))
                REG_START_X:     start_x_reg  <= cfg.data[POS_W-1:0];
                REG_START_Y:     start_y_reg  <= cfg.data[POS_W-1:0];
                REG_FACTOR_X:    factor_x_reg <= cfg.data[FACTOR_W-1:0];
                REG_FACTOR_Y:    factor_y_reg <= cfg.data[FACTOR_W-1:0];
                REG_POINTS_X:    points_x_reg <= cfg.data[POINTS_W-1:0];
                REG_POINTS_Y:    points_y_reg <= cfg.data[POINTS_W-1:0];
                REG_EXTRAPOLATE: extrap_reg   <= cfg.data[0];
                default:         ;
            endcase
        end
    end

    // Stage valid bits and load enables. A stage loads when it is empty or
    // when the stage after it loads in the same cycle.
    logic [NSTAGE:1] v_reg;
    logic [NSTAGE:1] ld;

    always_comb
    begin
        ld[NSTAGE] = !v_reg[NSTAGE] || rsp.ready;
        for (int k = NSTAGE - 1; k >= 1; k--)
        begin
            ld[k] = !v_reg[k] || ld[k+1];
        end
    end

    assign req.ready = ld[1];

    // Write payload travelling to the grid stage.
    cmd_t                       cmd1_reg, cmd2_reg, cmd3_reg;
    logic [CELL_W-1:0]          cx1_reg, cx2_reg, cx3_reg;
    logic [CELL_W-1:0]          cy1_reg, cy2_reg, cy3_reg;
    logic signed [HEIGHT_W-1:0] h1_reg, h2_reg, h3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (ld[1])
            begin
                v_reg[1] <= req.valid;
            end
            if (ld[2])
            begin
                v_reg[2] <= v_reg[1];
            end
            if (ld[3])
            begin
                v_reg[3] <= v_reg[2];
            end
            if (ld[4])
            begin
                v_reg[4] <= v_reg[3] && (cmd3_reg == CMD_QUERY);
            end
            for (int k = 5; k <= NSTAGE; k++)
            begin
                if (ld[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld[1])
        begin
            cmd1_reg <= req.command;
            cx1_reg  <= req.cell_x;
            cy1_reg  <= req.cell_y;
            h1_reg   <= req.height_in;
        end
        if (ld[2])
        begin
            cmd2_reg <= cmd1_reg;
            cx2_reg  <= cx1_reg;
            cy2_reg  <= cy1_reg;
            h2_reg   <= h1_reg;
        end
        if (ld[3])
        begin
            cmd3_reg <= cmd2_reg;
            cx3_reg  <= cx2_reg;
            cy3_reg  <= cy2_reg;
            h3_reg   <= h2_reg;
        end
    end

    // Per-axis cell and ratio, stages one to three.
    axis_en_t                  axis_en;
    logic [IWX-1:0]            gx3, nx3;
    logic [IWY-1:0]            gy3, ny3;
    logic signed [RATIO_W-1:0] fx3, fy3;

    assign axis_en = '{s1: ld[1], s2: ld[2], s3: ld[3]};

    bmo_axis #(.MAX_POINTS(MAX_POINTS_X)) u_axis_x (
        .clk    (clk),
        .en     (axis_en),
        .pos    (req.pos_x),
        .start  (start_x_reg),
        .factor (factor_x_reg),
        .points (points_x_reg),
        .extrap (extrap_reg),
        .g      (gx3),
        .n      (nx3),
        .f      (fx3)
    );

    bmo_axis #(.MAX_POINTS(MAX_POINTS_Y)) u_axis_y (
        .clk    (clk),
        .en     (axis_en),
        .pos    (req.pos_y),
        .start  (start_y_reg),
        .factor (factor_y_reg),
        .points (points_y_reg),
        .extrap (extrap_reg),
        .g      (gy3),
        .n      (ny3),
        .f      (fy3)
    );

    // Grid banks. Bank {y parity, x parity} holds the points of that parity,
    // so a cell's corners always fall in different banks unless they coincide.
    logic                 wr_ok;
    logic [BAW-1:0]       waddr;
    logic [3:0]           bank_we;
    logic [3:0]           bank_re;
    logic [HEIGHT_W-1:0]  bank_q [4];

    assign wr_ok = (32'(cx3_reg) < MAX_POINTS_X) && (32'(cy3_reg) < MAX_POINTS_Y);
    assign waddr = BAW'(32'(cy3_reg >> 1) * BX + 32'(cx3_reg >> 1));

    for (genvar b = 0; b < 4; b++)
    begin : g_bank
        localparam logic PX = 1'(b % 2);
        localparam logic PY = 1'(b / 2);

        logic [IWX:0]   xsel;
        logic [IWY:0]   ysel;
        logic [BAW-1:0] raddr;

        // Of the column pair {g, g + 1}, this bank holds the one of its parity.
        assign xsel  = (gx3[0] == PX) ? (IWX+1)'(gx3) : (IWX+1)'(gx3) + (IWX+1)'(1);
        assign ysel  = (gy3[0] == PY) ? (IWY+1)'(gy3) : (IWY+1)'(gy3) + (IWY+1)'(1);
        assign raddr = BAW'(32'(ysel >> 1) * BX + 32'(xsel >> 1));

        assign bank_we[b] = ld[4] && v_reg[3] && (cmd3_reg == CMD_WRITE) && wr_ok
                            && (cx3_reg[0] == PX) && (cy3_reg[0] == PY);
        assign bank_re[b] = ld[4] && v_reg[3] && (cmd3_reg == CMD_QUERY);

        bmo_ram #(.WIDTH(HEIGHT_W), .DEPTH(BANK_DEPTH)) u_ram (
            .clk   (clk),
            .we    (bank_we[b]),
            .waddr (waddr),
            .wdata (h3_reg),
            .re    (bank_re[b]),
            .raddr (raddr),
            .rdata (bank_q[b])
        );
    end

    // Stage four: corner selection and the two Y blends.
    logic [IWX-1:0]            gx4_reg, nx4_reg;
    logic [IWY-1:0]            gy4_reg, ny4_reg;
    logic signed [RATIO_W-1:0] fx4_reg, fy4_reg;

    always_ff @(posedge clk)
    begin
        if (ld[4])
        begin
            gx4_reg <= gx3;
            nx4_reg <= nx3;
            gy4_reg <= gy3;
            ny4_reg <= ny3;
            fx4_reg <= fx3;
            fy4_reg <= fy3;
        end
    end

    logic signed [HEIGHT_W-1:0] z1_c, z2_c, z3_c, z4_c;
    logic signed [DIFF_W-1:0]   d1_c, d2_c;
    logic signed [PY_W-1:0]     p1_next, p2_next;

    always_comb
    begin
        z1_c = bank_q[{gy4_reg[0], gx4_reg[0]}];
        z2_c = bank_q[{ny4_reg[0], gx4_reg[0]}];
        z3_c = bank_q[{gy4_reg[0], nx4_reg[0]}];
        z4_c = bank_q[{ny4_reg[0], nx4_reg[0]}];
        d1_c = {z2_c[HEIGHT_W-1], z2_c} - {z1_c[HEIGHT_W-1], z1_c};
        d2_c = {z4_c[HEIGHT_W-1], z4_c} - {z3_c[HEIGHT_W-1], z3_c};
        p1_next = d1_c * fy4_reg;
        p2_next = d2_c * fy4_reg;
    end

    logic signed [PY_W-1:0]     p1_5_reg, p2_5_reg;
    logic signed [HEIGHT_W-1:0] z1_5_reg, z3_5_reg;
    logic signed [RATIO_W-1:0]  fx5_reg, fx6_reg, fx7_reg;
    logic signed [LR_W-1:0]     l6_reg, r6_reg, l7_reg, l8_reg;
    logic signed [D2_W-1:0]     d7_reg;
    logic signed [PX_W-1:0]     px8_reg;
    logic signed [Z_W-1:0]      z_c;
    logic signed [HEIGHT_W-1:0] z_next;
    logic signed [HEIGHT_W-1:0] z_reg;

    always_comb
    begin
        z_c = {{(Z_W-LR_W){l8_reg[LR_W-1]}}, l8_reg}
              + {px8_reg[PX_W-1], px8_reg[PX_W-1:FRAC_W]};
        if ((&z_c[Z_W-1:HEIGHT_W-1]) || !(|z_c[Z_W-1:HEIGHT_W-1]))
        begin
            z_next = z_c[HEIGHT_W-1:0];
        end
        else if (z_c[Z_W-1])
        begin
            z_next = {1'b1, {(HEIGHT_W-1){1'b0}}};
        end
        else
        begin
            z_next = {1'b0, {(HEIGHT_W-1){1'b1}}};
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld[5])
        begin
            p1_5_reg <= p1_next;
            p2_5_reg <= p2_next;
            z1_5_reg <= z1_c;
            z3_5_reg <= z3_c;
            fx5_reg  <= fx4_reg;
        end
        if (ld[6])
        begin
            l6_reg  <= {{(LR_W-HEIGHT_W){z1_5_reg[HEIGHT_W-1]}}, z1_5_reg}
                       + {p1_5_reg[PY_W-1], p1_5_reg[PY_W-1:FRAC_W]};
            r6_reg  <= {{(LR_W-HEIGHT_W){z3_5_reg[HEIGHT_W-1]}}, z3_5_reg}
                       + {p2_5_reg[PY_W-1], p2_5_reg[PY_W-1:FRAC_W]};
            fx6_reg <= fx5_reg;
        end
        if (ld[7])
        begin
            d7_reg  <= {r6_reg[LR_W-1], r6_reg} - {l6_reg[LR_W-1], l6_reg};
            l7_reg  <= l6_reg;
            fx7_reg <= fx6_reg;
        end
        if (ld[8])
        begin
            px8_reg <= d7_reg * fx7_reg;
            l8_reg  <= l7_reg;
        end
        if (ld[9])
        begin
            z_reg <= z_next;
        end
    end

    assign rsp.valid    = v_reg[NSTAGE];
    assign rsp.z_offset = z_reg;

    // A single write lands in one bank at most.
    assert property (@(posedge clk) disable iff (!rst_n) $onehot0(bank_we))
        else $error("more than one grid bank written in a cycle");

    // Grid writes and reads never share a cycle.
    assert property (@(posedge clk) disable iff (!rst_n) !((|bank_we) && (|bank_re)))
        else $error("grid write and read in the same cycle");

    // The neighbor cell is the cell itself or the next one along each axis.
    assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[3] && cmd3_reg == CMD_QUERY)
        |-> ((nx3 == gx3 || 32'(nx3) == 32'(gx3) + 1)
             && (ny3 == gy3 || 32'(ny3) == 32'(gy3) + 1)))
        else $error("neighbor cell index out of step");

    // A full stage behind a stalled result is held, not dropped.
    assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[NSTAGE] && !rsp.ready && v_reg[NSTAGE-1]) |=> v_reg[NSTAGE-1])
        else $error("stage lost while result stalled");

endmodule
